// ----- hdl/ttsd_pkg.sv -----
package ttsd_pkg;

  // display positions written per temperature
  localparam int DIGIT_COUNT = 8;
  localparam int POS_W       = 4;

  // scaled value: whole*1000 + rounded fraction + 50 fits in 21 bits
  localparam int BIN_W      = 21;
  localparam int BCD_DIGITS = 7;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  // digits of the tenths value are BCD digits 2..6 of the scaled value
  localparam int VAL_DIGITS = 5;
  localparam int VAL_LSB    = 8;

  localparam logic [9:0] SCALE_WHOLE = 10'd1000;
  localparam logic [6:0] ROUND_HUND  = 7'd50;

  localparam logic [7:0] CODE_MINUS = 8'h0A;
  localparam logic [7:0] CODE_BLANK = 8'h0F;
  localparam logic [7:0] POINT_BIT  = 8'h80;

  // (frac*625 + 5) / 10 for each sixteenth
  localparam logic [9:0] FRAC_Q [16] = '{
    10'd0,   10'd63,  10'd125, 10'd188, 10'd250, 10'd313, 10'd375, 10'd438,
    10'd500, 10'd563, 10'd625, 10'd688, 10'd750, 10'd813, 10'd875, 10'd938
  };

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_CONV = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  typedef struct packed {
    logic             negative;
    logic [POS_W-1:0] point;
    logic [POS_W-1:0] pos;
  } emit_ctl_t;

endpackage

// ----- hdl/ttsd_dabble.sv -----
// one double-dabble step: add 3 to every BCD digit >= 5, then shift left by one
module ttsd_dabble (
  input  logic [ttsd_pkg::BCD_W-1:0] bcd,
  input  logic [ttsd_pkg::BIN_W-1:0] bin,
  output logic [ttsd_pkg::BCD_W-1:0] bcd_next,
  output logic [ttsd_pkg::BIN_W-1:0] bin_next
);

  logic [ttsd_pkg::BCD_W-1:0] adj;

  always_comb begin
    for (int i = 0; i < ttsd_pkg::BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign bcd_next = {adj[ttsd_pkg::BCD_W-2:0], bin[ttsd_pkg::BIN_W-1]};
  assign bin_next = {bin[ttsd_pkg::BIN_W-2:0], 1'b0};

endmodule

// ----- hdl/ttsd_code.sv -----
// code for one display position: digit (with point), minus, or blank
module ttsd_code (
  input  logic [4*ttsd_pkg::VAL_DIGITS-1:0] digits,
  input  ttsd_pkg::emit_ctl_t               ctl,
  output logic [7:0]                        code
);

  logic [2:0] ndig;
  logic       is_zero;
  logic [3:0] dig;
  logic       point_hit;

  always_comb begin
    is_zero = (digits == '0);
    priority if (digits[19:16] != 4'd0) ndig = 3'd5;
    else if (digits[15:12] != 4'd0)     ndig = 3'd4;
    else if (digits[11:8] != 4'd0)      ndig = 3'd3;
    else if (digits[7:4] != 4'd0)       ndig = 3'd2;
    else                                ndig = 3'd1;  // also a lone zero
  end

  always_comb begin
    unique case (ctl.pos)
      4'd1:    dig = digits[3:0];
      4'd2:    dig = digits[7:4];
      4'd3:    dig = digits[11:8];
      4'd4:    dig = digits[15:12];
      4'd5:    dig = digits[19:16];
      default: dig = 4'd0;
    endcase
  end

  assign point_hit = (ctl.pos == ctl.point) && !is_zero;

  always_comb begin
    priority if (ctl.pos <= {1'b0, ndig}) begin
      code = {4'd0, dig} | (point_hit ? ttsd_pkg::POINT_BIT : 8'd0);
    end else if (ctl.negative && (ctl.pos == ({1'b0, ndig} + 4'd1))) begin
      code = ttsd_pkg::CODE_MINUS;
    end else begin
      code = ttsd_pkg::CODE_BLANK;
    end
  end

endmodule

// ----- hdl/temperature_to_segment_digits.sv -----
// Temperature to seven-segment digit writes. Pulse start while busy is low to
// hand in raw_temperature (signed, 1/16 degree). The block then produces eight
// display writes, positions 1..8, one per cycle, each marked by result_strobe
// for a single cycle; the receiver must take every beat as it comes, there is
// no back-pressure. From acceptance until busy falls, an item passes through a
// scaling state for the magnitude (one multiply), the bit-serial binary-to-BCD
// shift unit, and the writes. The last write beat is strobed in the first cycle
// with busy low. point_position is written through cfg_valid/cfg_ready (always
// ready) and should change only while idle.
module temperature_to_segment_digits (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] raw_temperature,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         point_position,
  output logic               result_strobe,
  output logic [3:0]         digit_register,
  output logic [7:0]         digit_code,
  output logic               last_write
);

  ttsd_pkg::state_t               state;
  logic [3:0]                     point;
  logic                           negative;
  logic [15:0]                    mag;
  logic [ttsd_pkg::BIN_W-1:0]     bin;
  logic [ttsd_pkg::BCD_W-1:0]     bcd;
  logic [ttsd_pkg::BIN_W-1:0]     bin_next;
  logic [ttsd_pkg::BCD_W-1:0]     bcd_next;
  logic [4:0]                     cnt;
  logic [ttsd_pkg::POS_W-1:0]     pos;
  logic [15:0]                    raw_u;
  logic [21:0]                    scaled;
  ttsd_pkg::emit_ctl_t            ctl;
  logic [7:0]                     code;
  logic                           accept;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ttsd_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign raw_u     = raw_temperature;

  assign scaled = 22'(mag[15:4]) * 22'(ttsd_pkg::SCALE_WHOLE)
                + 22'(ttsd_pkg::FRAC_Q[mag[3:0]])
                + 22'(ttsd_pkg::ROUND_HUND);

  ttsd_dabble u_dabble (
    .bcd      (bcd),
    .bin      (bin),
    .bcd_next (bcd_next),
    .bin_next (bin_next)
  );

  assign ctl.negative = negative;
  assign ctl.point    = point;
  assign ctl.pos      = pos;

  ttsd_code u_code (
    .digits (bcd[ttsd_pkg::VAL_LSB +: 4*ttsd_pkg::VAL_DIGITS]),
    .ctl    (ctl),
    .code   (code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      point <= 4'd2;
    end else if (cfg_valid && cfg_ready) begin
      point <= point_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ttsd_pkg::S_IDLE;
      result_strobe <= 1'b0;
      cnt           <= '0;
      pos           <= '0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        ttsd_pkg::S_IDLE: begin
          if (accept) begin
            state <= ttsd_pkg::S_MUL;
          end
        end
        ttsd_pkg::S_MUL: begin
          cnt   <= '0;
          state <= ttsd_pkg::S_CONV;
        end
        ttsd_pkg::S_CONV: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(ttsd_pkg::BIN_W - 1)) begin
            pos   <= 4'd1;
            state <= ttsd_pkg::S_EMIT;
          end
        end
        ttsd_pkg::S_EMIT: begin
          result_strobe <= 1'b1;
          pos           <= pos + 4'd1;
          if (pos == 4'(ttsd_pkg::DIGIT_COUNT)) begin
            state <= ttsd_pkg::S_IDLE;
          end
        end
        default: state <= ttsd_pkg::S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      negative <= raw_u[15];
      mag      <= raw_u[15] ? (~raw_u + 16'd1) : raw_u;
    end
    if (state == ttsd_pkg::S_MUL) begin
      bin <= scaled[ttsd_pkg::BIN_W-1:0];
      bcd <= '0;
    end else if (state == ttsd_pkg::S_CONV) begin
      bin <= bin_next;
      bcd <= bcd_next;
    end
    if (state == ttsd_pkg::S_EMIT) begin
      digit_register <= pos;
      digit_code     <= code;
      last_write     <= (pos == 4'(ttsd_pkg::DIGIT_COUNT));
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after accepted item");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last_write |=> !result_strobe)
    else $error("write beat follows last write");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> (digit_register >= 4'd1) &&
                      (digit_register <= 4'(ttsd_pkg::DIGIT_COUNT)))
    else $error("digit register out of range");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last_write |=>
      result_strobe && (digit_register == $past(digit_register) + 4'd1))
    else $error("write beats not consecutive");

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last_write |-> busy)
    else $error("writes pending while idle");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    logic [3:0] pos;
    logic [7:0] code;
    logic       last;
  } digit_write_t;

  // pt: point setting for the row, codes: byte k is the code for position k+1
  typedef struct packed {
    logic [3:0]  pt;
    logic [15:0] temp;
    logic        typed;
    logic [63:0] codes;
  } temp_row_t;

  localparam int ROWS = 20;
  localparam logic [63:0] ZERO_CODES = 64'h0F0F0F0F_0F0F0F00;

  temp_row_t temp_tab [ROWS] = '{
    '{4'd2,  16'h0000, 1'b1, ZERO_CODES},
    '{4'd2,  16'h8000, 1'b1, 64'h0F0F0A02_00048800},
    '{4'd2,  16'h7FFF, 1'b1, 64'h0F0F0F02_00048709},
    '{4'd2,  16'h0001, 1'b0, 64'd0},
    '{4'd2,  16'hFFFF, 1'b0, 64'd0},
    '{4'd2,  16'h0008, 1'b0, 64'd0},
    '{4'd2,  16'h0010, 1'b0, 64'd0},
    '{4'd1,  16'h0000, 1'b1, ZERO_CODES},
    '{4'd1,  16'h0010, 1'b0, 64'd0},
    '{4'd1,  16'h8000, 1'b0, 64'd0},
    '{4'd8,  16'h7FFF, 1'b0, 64'd0},
    '{4'd8,  16'hFFF0, 1'b0, 64'd0},
    '{4'd5,  16'h7FFF, 1'b0, 64'd0},
    '{4'd5,  16'h8001, 1'b0, 64'd0},
    '{4'd0,  16'h0190, 1'b0, 64'd0},
    '{4'd0,  16'hFE70, 1'b0, 64'd0},
    '{4'd9,  16'h5555, 1'b0, 64'd0},
    '{4'd15, 16'hAAAA, 1'b0, 64'd0},
    '{4'd3,  16'h0008, 1'b0, 64'd0},
    '{4'd3,  16'h000F, 1'b0, 64'd0}
  };

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [15:0] raw_temperature;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [3:0]         point_position;
  logic               result_strobe;
  logic [3:0]         digit_register;
  logic [7:0]         digit_code;
  logic               last_write;

  digit_write_t writes_q[$];
  logic [3:0]   point_cfg = 4'd2;
  bit           steady;
  int           fails;

  temperature_to_segment_digits dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .raw_temperature (raw_temperature),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .point_position  (point_position),
    .result_strobe   (result_strobe),
    .digit_register  (digit_register),
    .digit_code      (digit_code),
    .last_write      (last_write)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic void push_write(int p, logic [7:0] code);
    digit_write_t w;
    w.pos  = p[3:0];
    w.code = code;
    w.last = (p == ttsd_pkg::DIGIT_COUNT);
    writes_q.push_back(w);
  endfunction

  // magnitude, round to tenths, then digits lsd first, minus, blanks
  function automatic void predict_writes(logic [15:0] t, logic [3:0] pt);
    logic [15:0] mag;
    logic [7:0]  code;
    int          tenths;
    int          p;
    mag = t[15] ? 16'(~t + 16'd1) : t;
    tenths = (int'(mag[15:4]) * 1000 + (int'(mag[3:0]) * 625 + 5) / 10 + 50) / 100;
    p = 1;
    if (tenths == 0) begin
      push_write(p, 8'h00);
      p++;
    end
    while (tenths > 0 && p <= ttsd_pkg::DIGIT_COUNT) begin
      code = 8'(tenths % 10);
      if (p == pt) code = code | ttsd_pkg::POINT_BIT;
      push_write(p, code);
      p++;
      tenths = tenths / 10;
    end
    if (t[15] && p <= ttsd_pkg::DIGIT_COUNT) begin
      push_write(p, ttsd_pkg::CODE_MINUS);
      p++;
    end
    while (p <= ttsd_pkg::DIGIT_COUNT) begin
      push_write(p, ttsd_pkg::CODE_BLANK);
      p++;
    end
  endfunction

  task automatic send_temp(logic [15:0] t, logic typed, logic [63:0] codes);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start           <= 1'b1;
    raw_temperature <= t;
    do @(posedge clk); while (busy);
    if (typed) begin
      for (int k = 0; k < ttsd_pkg::DIGIT_COUNT; k++) push_write(k + 1, codes[8*k +: 8]);
    end else begin
      predict_writes(t, point_cfg);
    end
  endtask

  task automatic wait_writes_done();
    @(negedge clk);
    start <= 1'b0;
    while (writes_q.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_point(logic [3:0] v);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    point_position <= v;
    do @(posedge clk); while (!cfg_ready);
    point_cfg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_temp();
    logic [15:0] t;
    case ($urandom_range(0, 4))
      0, 1: t = 16'($urandom);
      2: t = 16'($urandom_range(0, 160)) * (($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd1);
      3: begin
        case ($urandom_range(0, 4))
          0: t = 16'h8000;
          1: t = 16'h7FFF;
          2: t = 16'h8001;
          3: t = 16'hFFFF;
          default: t = 16'h0000;
        endcase
      end
      default: t = {4'($urandom_range(0, 15)) & 4'h1, 8'($urandom), 4'($urandom)};
    endcase
    return t;
  endfunction

  // results cannot be held off: check every strobed beat as it comes
  always @(posedge clk) begin
    digit_write_t w;
    if (!rst && result_strobe) begin
      if (writes_q.size() == 0) begin
        $error("unexpected digit write: digit_register=%0d digit_code=%h", digit_register,
               digit_code);
        fails++;
      end else begin
        w = writes_q.pop_front();
        if (digit_register !== w.pos) begin
          $error("digit_register: expected %0d, got %0d", w.pos, digit_register);
          fails++;
        end
        if (digit_code !== w.code) begin
          $error("digit_code: expected %h, got %h", w.code, digit_code);
          fails++;
        end
        if (last_write !== w.last) begin
          $error("last_write: expected %0d, got %0d", w.last, last_write);
          fails++;
        end
      end
    end
  end

  initial begin
    logic [3:0] phase_pts [6];
    rst             = 1'b1;
    start           = 1'b0;
    raw_temperature = '0;
    cfg_valid       = 1'b0;
    point_position  = 4'd2;
    fails           = 0;
    steady          = 1'b0;
    phase_pts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'($urandom_range(0, 15))};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (temp_tab[i]) begin
      if (temp_tab[i].pt != point_cfg) begin
        wait_writes_done();
        write_point(temp_tab[i].pt);
      end
      send_temp(temp_tab[i].temp, temp_tab[i].typed, temp_tab[i].codes);
    end

    for (int ph = 0; ph < 6; ph++) begin
      wait_writes_done();
      write_point(phase_pts[ph]);
      steady = (ph == 1 || ph == 4);
      for (int n = 0; n < 55; n++) begin
        // mid-phase stretch where the sender waits for all writes to land
        if (n == 27 && ph == 3) wait_writes_done();
        send_temp(rand_temp(), 1'b0, 64'd0);
      end
    end

    wait_writes_done();
    repeat (40) @(posedge clk);
    if (fails == 0) begin
      $display("temperature_to_segment_digits verification clean");
    end else begin
      $display("temperature_to_segment_digits verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("temperature_to_segment_digits verification failed");
    $finish;
  end

endmodule
